>>> hdl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and helpers for the chunked body deframer.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Width of a chunk size and of the bytes-left counter.
    localparam int SIZE_BITS = 31;
    localparam int TOTAL_BITS = 32;

    // Characters that the framing recognizes.
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_HEX     = 3'd1,
        PH_HEX_LF  = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATA_CR = 3'd4,
        PH_DATA_LF = 3'd5,
        PH_LAST_CR = 3'd6,
        PH_LAST_LF = 3'd7
    } hcbd_phase_t;

    // Result classes.
    typedef enum logic [1:0] {
        K_FRAME = 2'd0,
        K_DATA  = 2'd1,
        K_DONE  = 2'd2,
        K_ERROR = 2'd3
    } hcbd_kind_t;

    // One result transaction.
    typedef struct packed {
        hcbd_kind_t              kind;
        logic [7:0]              payload;
        logic [TOTAL_BITS-1:0]   total_len;
    } hcbd_result_t;

    // Decoded hex digit: valid flag and value.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hcbd_hex_t;

    // Decode one ASCII hex digit.
    function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
        hcbd_hex_t r;
        logic [7:0] diff;
        r.ok = 1'b0;
        r.value = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            diff = c - CH_0;
            r.ok = 1'b1;
            r.value = diff[3:0];
        end
        else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            diff = c - CH_LOW_A + 8'd10;
            r.ok = 1'b1;
            r.value = diff[3:0];
        end
        else if (c >= CH_UP_A && c <= CH_UP_F) begin
            diff = c - CH_UP_A + 8'd10;
            r.ok = 1'b1;
            r.value = diff[3:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/hcbd_parser.sv
// ----------------------------------------------------------------------------
// hcbd_parser
// Per-byte framing state machine: holds the parse state and forms the result
// for the byte presented on each step.
// ----------------------------------------------------------------------------
module hcbd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    output hcbd_pkg::hcbd_result_t result
);

    localparam int SB = hcbd_pkg::SIZE_BITS;
    localparam int TB = hcbd_pkg::TOTAL_BITS;

    hcbd_pkg::hcbd_phase_t phase_reg, phase_next;
    logic [SB-1:0] accum_reg, accum_next;
    logic          ovf_reg, ovf_next;
    logic [SB-1:0] left_reg, left_next;
    logic [TB-1:0] total_reg, total_next;
    logic          err_reg, err_next;

    hcbd_pkg::hcbd_hex_t hex;
    logic [SB+3:0] shifted;
    logic [SB-1:0] accum_add;
    logic          ovf_add;
    logic [TB:0]   total_sum;
    logic [TB-1:0] total_sat;
    logic [SB-1:0] left_dec;
    logic [TB-1:0] len_value;
    logic          bad;
    logic          is_data;
    logic          is_done;

    // Shared datapath: hex digit append with overflow, saturating total, bytes-left decrement.
    always_comb
    begin
        hex = hcbd_pkg::hex_decode(data_byte);
        shifted = {accum_reg, 4'd0} + {{SB{1'b0}}, hex.value};
        ovf_add = ovf_reg || (shifted[SB+3:SB] != 4'd0);
        accum_add = ovf_add ? {SB{1'b1}} : shifted[SB-1:0];
        total_sum = {1'b0, total_reg} + {{(TB+1-SB){1'b0}}, accum_reg};
        total_sat = total_sum[TB] ? {TB{1'b1}} : total_sum[TB-1:0];
        left_dec = left_reg - {{(SB-1){1'b0}}, (left_reg != '0)};
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        left_next  = left_reg;
        total_next = total_reg;
        err_next   = err_reg;
        bad        = 1'b0;
        is_data    = 1'b0;
        is_done    = 1'b0;
        if (err_reg) begin
            bad = 1'b1;
        end
        else begin
            case (phase_reg)
                hcbd_pkg::PH_START:
                begin
                    if (hex.ok) begin
                        accum_next = {{(SB-4){1'b0}}, hex.value};
                        ovf_next   = 1'b0;
                        phase_next = hcbd_pkg::PH_HEX;
                    end
                    else begin
                        bad = 1'b1;
                    end
                end
                hcbd_pkg::PH_HEX:
                begin
                    if (hex.ok) begin
                        accum_next = accum_add;
                        ovf_next   = ovf_add;
                    end
                    else if (data_byte == hcbd_pkg::CH_LOW_X ||
                             data_byte == hcbd_pkg::CH_UP_X) begin
                        // An x or X inside the size line is skipped.
                    end
                    else if (data_byte == hcbd_pkg::CH_CR) begin
                        phase_next = hcbd_pkg::PH_HEX_LF;
                    end
                    else begin
                        bad = 1'b1;
                    end
                end
                hcbd_pkg::PH_HEX_LF:
                begin
                    if (data_byte != hcbd_pkg::CH_LF || ovf_reg) begin
                        bad = 1'b1;
                    end
                    else begin
                        total_next = total_sat;
                        if (accum_reg != '0) begin
                            left_next  = accum_reg;
                            phase_next = hcbd_pkg::PH_DATA;
                        end
                        else begin
                            phase_next = hcbd_pkg::PH_LAST_CR;
                        end
                        accum_next = '0;
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    is_data   = 1'b1;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = hcbd_pkg::PH_DATA_CR;
                    end
                end
                hcbd_pkg::PH_DATA_CR:
                begin
                    if (data_byte == hcbd_pkg::CH_CR) begin
                        phase_next = hcbd_pkg::PH_DATA_LF;
                    end
                    else begin
                        bad = 1'b1;
                    end
                end
                hcbd_pkg::PH_DATA_LF:
                begin
                    if (data_byte == hcbd_pkg::CH_LF) begin
                        phase_next = hcbd_pkg::PH_START;
                    end
                    else begin
                        bad = 1'b1;
                    end
                end
                hcbd_pkg::PH_LAST_CR:
                begin
                    if (data_byte == hcbd_pkg::CH_CR) begin
                        phase_next = hcbd_pkg::PH_LAST_LF;
                    end
                    else begin
                        bad = 1'b1;
                    end
                end
                default:
                begin
                    if (data_byte == hcbd_pkg::CH_LF) begin
                        is_done = 1'b1;
                    end
                    else begin
                        bad = 1'b1;
                    end
                end
            endcase
        end

        // The length reported is the total after this byte's update.
        len_value = total_next;

        // An illegal byte only latches the error; completion starts a new body.
        if (bad) begin
            err_next = 1'b1;
        end
        else if (is_done) begin
            phase_next = hcbd_pkg::PH_START;
            accum_next = '0;
            ovf_next   = 1'b0;
            left_next  = '0;
            total_next = '0;
        end
    end

    // Result for the current byte.
    always_comb
    begin
        result.kind      = hcbd_pkg::K_FRAME;
        result.payload   = 8'd0;
        result.total_len = len_value;
        if (bad) begin
            result.kind      = hcbd_pkg::K_ERROR;
            result.total_len = '0;
        end
        else if (is_done) begin
            result.kind = hcbd_pkg::K_DONE;
        end
        else if (is_data) begin
            result.kind    = hcbd_pkg::K_DATA;
            result.payload = data_byte;
        end
    end

    // State registers advance once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= hcbd_pkg::PH_START;
            accum_reg <= '0;
            ovf_reg   <= 1'b0;
            left_reg  <= '0;
            total_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (step) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            ovf_reg   <= ovf_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> hdl/http_chunked_body_deframer_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_deframer_top
// Takes an HTTP chunked body one byte per cycle unless the output stalls, and
// returns one result transaction per byte. Every byte accepted on the input
// channel produces exactly one result, classed as framing, payload, body
// complete (carrying the summed chunk sizes) or error; the error is sticky
// until reset. A byte is parsed in the cycle it is accepted and its result is
// registered, so the result appears in the next cycle. The input is ready
// whenever the result register is empty or being drained, so a new byte can be
// taken every cycle while results are consumed; the single output register is
// what limits throughput under output stall.
// ----------------------------------------------------------------------------
module http_chunked_body_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload,
    output logic [31:0] total_len
);

    hcbd_pkg::hcbd_result_t result;
    hcbd_pkg::hcbd_result_t result_reg;
    logic                   out_valid_reg;
    logic                   accept;

    // Take a new transaction whenever the result register will be free.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    hcbd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .data_byte (data_byte),
        .result    (result)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = result_reg.kind;
    assign payload   = result_reg.payload;
    assign total_len = result_reg.total_len;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HTTP chunked body deframer. A short table of
// hand-built bytes runs first. Random well-formed bodies with varied size-line
// spelling and random payload follow. An oversized size line then trips the
// sticky error, and random noise closes the run. Each result is checked against a
// typed row's own result or else a cycle-free model of the parser in the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int CLEAN_TARGET  = 465;
    localparam int NOISE_BYTES   = 32;
    localparam int TABLE_ROWS    = 27;
    localparam int TABLE_CLEAN   = 15;
    localparam int DRAIN_CYCLES  = 8;

    // One row of the hand-built stimulus; typed rows carry their own result.
    typedef struct packed {
        logic [7:0]           chr;
        logic                 typed;
        hcbd_pkg::hcbd_kind_t kind;
        logic [7:0]           pay;
        logic [31:0]          len;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [31:0] total_len;

    // Parser state as the bench sees it.
    hcbd_pkg::hcbd_phase_t          parse_phase;
    logic [hcbd_pkg::SIZE_BITS-1:0] size_acc;
    logic                           size_ovf;
    logic [hcbd_pkg::SIZE_BITS-1:0] chunk_left;
    logic [31:0]                    body_total;
    logic                           err_sticky;

    hcbd_pkg::hcbd_result_t owed_results[$];
    hcbd_pkg::hcbd_result_t head_result;

    int  sent_count = 0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  bodies_done = 0;
    int  payload_seen = 0;
    int  errors_seen = 0;
    int  hold_cnt = 0;
    bit  no_idle = 1'b0;

    // Bytes 0..14 form one clean body; 15..26 are the oversized size line
    // followed by bytes that must stay in error.
    stim_row_t stim_table [0:TABLE_ROWS-1] = '{
        '{hcbd_pkg::CH_0,     1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_LOW_X, 1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{8'h32,              1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_LF,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{8'h00,              1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{8'hFF,              1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_LF,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_0,     1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_UP_X,  1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_LF,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd2},
        '{hcbd_pkg::CH_LF,    1'b1, hcbd_pkg::K_DONE,  8'h00, 32'd2},
        '{8'h38,              1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_0,     1'b0, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::K_FRAME, 8'h00, 32'd0},
        '{hcbd_pkg::CH_LF,    1'b1, hcbd_pkg::K_ERROR, 8'h00, 32'd0},
        '{8'h31,              1'b1, hcbd_pkg::K_ERROR, 8'h00, 32'd0},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::K_ERROR, 8'h00, 32'd0}
    };

    http_chunked_body_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .payload   (payload),
        .total_len (total_len)
    );

    always #10 clk = ~clk;

    // Clear the bench's copy of the parser.
    task automatic clear_parser();
        parse_phase = hcbd_pkg::PH_START;
        size_acc    = '0;
        size_ovf    = 1'b0;
        chunk_left  = '0;
        body_total  = '0;
        err_sticky  = 1'b0;
    endtask

    // Value of a hex digit, or -1 for any other byte.
    function automatic int digit_value(input logic [7:0] c);
        if (c >= hcbd_pkg::CH_0 && c <= hcbd_pkg::CH_9)
            return int'(c) - int'(hcbd_pkg::CH_0);
        if (c >= hcbd_pkg::CH_LOW_A && c <= hcbd_pkg::CH_LOW_F)
            return int'(c) - int'(hcbd_pkg::CH_LOW_A) + 10;
        if (c >= hcbd_pkg::CH_UP_A && c <= hcbd_pkg::CH_UP_F)
            return int'(c) - int'(hcbd_pkg::CH_UP_A) + 10;
        return -1;
    endfunction

    // Shift one digit into the size; an oversized size pins at all ones.
    task automatic shift_digit(input int d);
        logic [35:0] grown;
        grown = ({5'd0, size_acc} << 4) + 36'(d);
        if (size_ovf || grown > 36'h7FFF_FFFF)
        begin
            size_ovf = 1'b1;
            size_acc = '1;
        end
        else
        begin
            size_acc = grown[hcbd_pkg::SIZE_BITS-1:0];
        end
    endtask

    // Advance the parser by one byte and return the result it owes.
    task automatic deframe_byte(input logic [7:0] c,
                                output hcbd_pkg::hcbd_result_t res);
        int          d;
        logic        bad;
        logic [32:0] sum;
        d = digit_value(c);
        bad = 1'b0;
        res = '0;
        res.kind = hcbd_pkg::K_FRAME;
        if (err_sticky)
        begin
            bad = 1'b1;
        end
        else
        begin
            case (parse_phase)
                hcbd_pkg::PH_START:
                begin
                    if (d >= 0)
                    begin
                        size_acc = '0;
                        size_ovf = 1'b0;
                        shift_digit(d);
                        parse_phase = hcbd_pkg::PH_HEX;
                    end
                    else bad = 1'b1;
                end
                hcbd_pkg::PH_HEX:
                begin
                    if (d >= 0) shift_digit(d);
                    else if (c == hcbd_pkg::CH_LOW_X || c == hcbd_pkg::CH_UP_X) ;
                    else if (c == hcbd_pkg::CH_CR) parse_phase = hcbd_pkg::PH_HEX_LF;
                    else bad = 1'b1;
                end
                hcbd_pkg::PH_HEX_LF:
                begin
                    if (c != hcbd_pkg::CH_LF || size_ovf)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        sum = {1'b0, body_total} + 33'(size_acc);
                        body_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        if (size_acc != '0)
                        begin
                            chunk_left = size_acc;
                            parse_phase = hcbd_pkg::PH_DATA;
                        end
                        else parse_phase = hcbd_pkg::PH_LAST_CR;
                        size_acc = '0;
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    res.kind = hcbd_pkg::K_DATA;
                    res.payload = c;
                    if (chunk_left != '0)
                        chunk_left = chunk_left - {{(hcbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
                    if (chunk_left == '0) parse_phase = hcbd_pkg::PH_DATA_CR;
                end
                hcbd_pkg::PH_DATA_CR:
                begin
                    if (c == hcbd_pkg::CH_CR) parse_phase = hcbd_pkg::PH_DATA_LF;
                    else bad = 1'b1;
                end
                hcbd_pkg::PH_DATA_LF:
                begin
                    if (c == hcbd_pkg::CH_LF) parse_phase = hcbd_pkg::PH_START;
                    else bad = 1'b1;
                end
                hcbd_pkg::PH_LAST_CR:
                begin
                    if (c == hcbd_pkg::CH_CR) parse_phase = hcbd_pkg::PH_LAST_LF;
                    else bad = 1'b1;
                end
                default:
                begin
                    if (c == hcbd_pkg::CH_LF) res.kind = hcbd_pkg::K_DONE;
                    else bad = 1'b1;
                end
            endcase
        end

        if (bad)
        begin
            err_sticky = 1'b1;
            res = '0;
            res.kind = hcbd_pkg::K_ERROR;
        end
        else
        begin
            res.total_len = body_total;
            if (res.kind == hcbd_pkg::K_DONE)
            begin
                parse_phase = hcbd_pkg::PH_START;
                size_acc    = '0;
                size_ovf    = 1'b0;
                chunk_left  = '0;
                body_total  = '0;
            end
        end
    endtask

    // Offer one byte, wait for the transaction, and queue the owed result.
    // A typed result from the table takes the place of the predicted one.
    task automatic drive_byte(input logic [7:0] b, input logic typed,
                              input hcbd_pkg::hcbd_result_t tab_res);
        hcbd_pkg::hcbd_result_t want;
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        deframe_byte(b, want);
        if (typed) want = tab_res;
        owed_results.push_back(want);
        sent_count++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        drive_byte(b, 1'b0, '0);
    endtask

    task automatic drive_row(input int i);
        hcbd_pkg::hcbd_result_t r;
        r.kind      = stim_table[i].kind;
        r.payload   = stim_table[i].pay;
        r.total_len = stim_table[i].len;
        drive_byte(stim_table[i].chr, stim_table[i].typed, r);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
            return hcbd_pkg::CH_0 + 8'(v);
        return (upper ? hcbd_pkg::CH_UP_A : hcbd_pkg::CH_LOW_A) + 8'(v - 4'd10);
    endfunction

    // Size line with random leading zeros, x marks and letter case.
    task automatic send_size_line(input int size);
        logic [31:0] v;
        int          zeros;
        int          top;
        int          n;
        v = size;
        zeros = $urandom_range(0, 2);
        if (size == 0 && zeros == 0) zeros = 1;
        top = -1;
        for (n = 7; n >= 0; n--)
            if (top < 0 && v[n*4 +: 4] != 4'd0) top = n;
        for (n = 0; n < zeros; n++)
        begin
            push_byte(hcbd_pkg::CH_0);
            if (n == 0 && $urandom_range(0, 2) == 0)
                push_byte($urandom_range(0, 1) ? hcbd_pkg::CH_UP_X : hcbd_pkg::CH_LOW_X);
        end
        for (n = top; n >= 0; n--)
        begin
            push_byte(hex_char(v[n*4 +: 4], bit'($urandom_range(0, 1))));
            if ($urandom_range(0, 9) == 0) push_byte(hcbd_pkg::CH_LOW_X);
        end
        push_byte(hcbd_pkg::CH_CR);
        push_byte(hcbd_pkg::CH_LF);
    endtask

    // One well-formed body: a few chunks of random payload, then the last chunk.
    task automatic send_body();
        int chunks;
        int size;
        int i;
        chunks = $urandom_range(1, 4);
        for (i = 0; i < chunks; i++)
        begin
            if ($urandom_range(0, 7) == 0) size = $urandom_range(9, 64);
            else size = $urandom_range(1, 8);
            send_size_line(size);
            repeat (size) push_byte(8'($urandom_range(0, 255)));
            push_byte(hcbd_pkg::CH_CR);
            push_byte(hcbd_pkg::CH_LF);
        end
        send_size_line(0);
        push_byte(hcbd_pkg::CH_CR);
        push_byte(hcbd_pkg::CH_LF);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s expected 0x%0h, got 0x%0h",
                     cycle_count, field, want, got);
    endtask

    // Result side: random stall bursts, none while no_idle is set.
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (no_idle)
        begin
            out_ready <= 1'b1;
            hold_cnt <= 0;
        end
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        else if (out_ready && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            hold_cnt <= $urandom_range(0, 16);
        end
        else
        begin
            out_ready <= 1'b1;
            hold_cnt <= $urandom_range(0, 30);
        end
    end

    // Compare each result transaction with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch("unexpected result, kind", 32'd0, 32'(kind));
            end
            else
            begin
                head_result = owed_results.pop_front();
                if (kind !== head_result.kind)
                    report_mismatch("kind", 32'(head_result.kind), 32'(kind));
                if (payload !== head_result.payload)
                    report_mismatch("payload", 32'(head_result.payload), 32'(payload));
                if (total_len !== head_result.total_len)
                    report_mismatch("total_len", head_result.total_len, total_len);
                case (head_result.kind)
                    hcbd_pkg::K_DONE:  bodies_done++;
                    hcbd_pkg::K_DATA:  payload_seen++;
                    hcbd_pkg::K_ERROR: errors_seen++;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        int i;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clean body from the table.
        for (i = 0; i < TABLE_CLEAN; i++)
            drive_row(i);

        // Random well-formed bodies; some run without any idling.
        while (sent_count < CLEAN_TARGET)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            send_body();
        end

        // Oversized size line, sticky error, then noise, all without idling.
        no_idle = 1'b1;
        for (i = TABLE_CLEAN; i < TABLE_ROWS; i++)
            drive_row(i);
        repeat (NOISE_BYTES) push_byte(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes sent: %0d bodies completed, %0d payload bytes, %0d errors",
                 sent_count, bodies_done, payload_seen, errors_seen);
        $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> http_chunked_body_deframer_top.f
hdl/hcbd_pkg.sv
hdl/hcbd_parser.sv
hdl/http_chunked_body_deframer_top.sv
bench/testbench.sv
